/* sv/smd_pkg.sv */
`default_nettype none
package smd_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned SplitW = 15;

    typedef enum logic [1:0] {
        OP_MULT_ADD  = 2'd0,
        OP_DIV_N     = 2'd1,
        OP_FRAC      = 2'd2,
        OP_FRAC_RND  = 2'd3
    } t_op;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SETUP = 10'b0000000010,
        S_DIV1  = 10'b0000000100,
        S_DIV2  = 10'b0000001000,
        S_MUL1  = 10'b0000010000,
        S_MUL2  = 10'b0000100000,
        S_DIVA  = 10'b0001000000,
        S_DIVB  = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_SPARE = 10'b1000000000
    } t_state;

    function automatic logic [WordW-1:0] mag(input logic [WordW-1:0] a);
        mag = a[WordW-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic [WordW-1:0] neg_if(input logic s, input logic [WordW-1:0] a);
        neg_if = s ? (~a + 1'b1) : a;
    endfunction

endpackage
`default_nettype wire

/* sv/smd_mul.sv */
`default_nettype none
module smd_mul
    import smd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [WordW-1:0] i_a,
    input  wire logic [WordW-1:0] i_b,
    output logic                  o_done,
    output logic [WordW-1:0]      o_prod
);
    // shift-add, one multiplier bit per cycle, stops when multiplier runs out
    logic             r_busy, r_done;
    logic [WordW-1:0] r_a, r_b, r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_b == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && r_b != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[WordW-2:0], 1'b0};
            r_b <= {1'b0, r_b[WordW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

/* sv/smd_div.sv */
`default_nettype none
module smd_div
    import smd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [WordW-1:0] i_num,
    input  wire logic [WordW-1:0] i_den,
    output logic                  o_done,
    output logic [WordW-1:0]      o_quo,
    output logic [WordW-1:0]      o_rem
);
    // restoring division, one quotient bit per cycle
    localparam int unsigned CntW = $clog2(WordW + 1);

    logic [CntW-1:0]  r_cnt;
    logic             r_done;
    logic [WordW-1:0] r_rem, r_quo, r_den;
    logic [WordW:0]   trial, shifted;

    assign shifted = {r_rem, r_quo[WordW-1]};
    assign trial   = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_cnt <= CntW'(WordW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= trial[WordW] ? shifted[WordW-1:0] : trial[WordW-1:0];
            r_quo <= {r_quo[WordW-2:0], ~trial[WordW]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

/* sv/scaled_muldiv_unit.sv */
// scaled_muldiv_unit: 32-bit scaled integer arithmetic, one operation per transaction
// input stream: s_axis tuser carries req_type, tdata carries clear_error, operand_x,
//   operand_n, operand_y, mag_limit and operand_d
// output stream: m_axis tdata carries result, remainder and the sticky err_flag
// one input transaction gives exactly one output transaction, in order
// work is done by a shared serial multiplier, which stops when its multiplier operand
//   runs out, and a shared restoring divider
//   mult_add: 2 divides + 1 multiply on n
//   divide by n: 1 divide
//   x*n/d: multiplies on 15 and 17 bits of x plus 2 divides
//   zero divisor / zero n shortcuts go straight to the output state
// one operation is in flight at a time; s_tready is high only while idle, so the next
//   input is taken at the earliest in the cycle after the result is registered
// the finished transaction sits in an output register, so a new input can be taken
//   while the receiver stalls; the next result waits until that register drains
// reset clears the error flag, the remainder register and all handshake state
`default_nettype none
module scaled_muldiv_unit
    import smd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [159:0] i_s_tdata,  // clear_error, operand_x, operand_n, operand_y,
                                          // mag_limit, operand_d
    input  wire logic [1:0]   i_s_tuser,  // req_type
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [71:0]       o_m_tdata   // result, remainder, err_flag, zero pad
);

    t_state r_state, n_state;

    // captured operation
    logic [1:0]       r_op;
    logic [WordW-1:0] r_x, r_n, r_y, r_d;
    logic [30:0]      r_mx;
    logic             r_neg;      // sign fix-up for the final result and remainder
    logic             r_xneg;     // divide by n: dividend was negative
    logic             r_ovf;

    // architectural state
    logic             r_err;
    logic [WordW-1:0] r_remreg;

    // work registers
    logic [WordW-1:0] r_res, r_t, r_u, r_q1;
    logic             r_sq, r_sr;  // signs of quotient and remainder of a signed divide

    // output register
    logic             r_ovalid;
    logic [71:0]      r_odata;

    // sub-unit handshake
    logic             mul_go, div_go, mul_done, div_done;
    logic [WordW-1:0] mul_a, mul_b, div_num, div_den, prod, uquo, urem;
    logic [WordW-1:0] sq_val, sr_val;

    logic             acc;
    assign acc = i_s_tvalid && (r_state == S_IDLE);

    smd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    smd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (uquo),
        .o_rem   (urem)
    );

    // signed view of the last divide
    assign sq_val = neg_if(r_sq, uquo);
    assign sr_val = neg_if(r_sr, urem);

    // next-state values
    logic [WordW-1:0] n_x, n_n, n_res, n_t, n_u, n_q1, n_remreg;
    logic             n_err, n_neg, n_xneg, n_ovf, n_sq, n_sr;
    logic [WordW-1:0] sa, sb, xa, v, uf, mxw;
    logic             fire;

    assign mxw = {1'b0, r_mx};

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_n      = r_n;
        n_res    = r_res;
        n_t      = r_t;
        n_u      = r_u;
        n_q1     = r_q1;
        n_remreg = r_remreg;
        n_err    = r_err;
        n_neg    = r_neg;
        n_xneg   = r_xneg;
        n_ovf    = r_ovf;
        n_sq     = r_sq;
        n_sr     = r_sr;
        mul_go   = 1'b0;
        mul_a    = r_x;
        mul_b    = r_n;
        div_go   = 1'b0;
        sa       = '0;
        sb       = '0;
        xa       = '0;
        v        = '0;
        uf       = '0;
        fire     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = S_SETUP;
                    if (i_s_tdata[0]) begin
                        n_err = 1'b0;
                    end
                end
            end
            S_SETUP: begin
                case (r_op)
                    OP_MULT_ADD: begin
                        if (r_n == '0) begin
                            n_res   = r_y;
                            n_state = S_OUT;
                        end else begin
                            n_x     = neg_if(r_n[WordW-1], r_x);
                            n_n     = neg_if(r_n[WordW-1], r_n);
                            sa      = mxw - r_y;
                            sb      = n_n;
                            fire    = 1'b1;
                            n_state = S_DIV1;
                        end
                    end
                    OP_DIV_N: begin
                        if (r_n == '0) begin
                            n_err    = 1'b1;
                            n_remreg = r_x;
                            n_res    = '0;
                            n_state  = S_OUT;
                        end else begin
                            n_neg   = r_n[WordW-1];
                            xa      = neg_if(r_n[WordW-1], r_x);
                            n_n     = neg_if(r_n[WordW-1], r_n);
                            n_xneg  = xa[WordW-1];
                            sa      = neg_if(xa[WordW-1], xa);
                            sb      = n_n;
                            fire    = 1'b1;
                            n_state = S_DIV1;
                        end
                    end
                    default: begin
                        if (r_d == '0) begin
                            n_err   = 1'b1;
                            n_res   = '0;
                            n_state = S_OUT;
                        end else begin
                            n_x     = mag(r_x);
                            n_n     = (r_op == OP_FRAC) ? r_n : mag(r_n);
                            n_neg   = (r_op == OP_FRAC) ? r_x[WordW-1]
                                                        : (r_x[WordW-1] ^ r_n[WordW-1]);
                            mul_go  = 1'b1;
                            mul_a   = n_n;
                            mul_b   = {{(WordW-SplitW){1'b0}}, n_x[SplitW-1:0]};
                            n_state = S_MUL1;
                        end
                    end
                endcase
            end
            S_DIV1: begin
                if (div_done) begin
                    if (r_op == OP_MULT_ADD) begin
                        n_q1    = sq_val;
                        sa      = mxw + r_y;
                        sb      = r_n;
                        fire    = 1'b1;
                        n_state = S_DIV2;
                    end else begin
                        n_res    = neg_if(r_xneg, sq_val);
                        n_remreg = neg_if(r_neg, neg_if(r_xneg, sr_val));
                        n_state  = S_OUT;
                    end
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    n_t     = sq_val;
                    mul_go  = 1'b1;
                    mul_a   = r_x;
                    mul_b   = r_n;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                if (mul_done) begin
                    if (r_op == OP_MULT_ADD) begin
                        if ($signed(r_x) <= $signed(r_q1)
                            && $signed(~r_x + 1'b1) <= $signed(r_t)) begin
                            n_res = prod + r_y;
                        end else begin
                            n_err = 1'b1;
                            n_res = '0;
                        end
                        n_state = S_OUT;
                    end else begin
                        n_t     = prod;
                        mul_go  = 1'b1;
                        mul_a   = r_n;
                        mul_b   = {{SplitW{1'b0}}, r_x[WordW-1:SplitW]};
                        n_state = S_MUL2;
                    end
                end
            end
            S_MUL2: begin
                if (mul_done) begin
                    n_u     = prod + {{SplitW{1'b0}}, r_t[WordW-1:SplitW]};
                    n_sq    = 1'b0;
                    n_sr    = 1'b0;
                    div_go  = 1'b1;
                    n_state = S_DIVA;
                end
            end
            S_DIVA: begin
                if (div_done) begin
                    // high quotient of 2^15 or more overflows the split
                    n_ovf = (uquo[WordW-1:SplitW] != '0);
                    if (uquo[WordW-1:SplitW] == '0) begin
                        n_u = {uquo[WordW-SplitW-1:0], {SplitW{1'b0}}};
                    end
                    v       = {urem[WordW-SplitW-1:0], r_t[SplitW-1:0]};
                    div_go  = 1'b1;
                    n_state = S_DIVB;
                end
            end
            S_DIVB: begin
                if (div_done) begin
                    uf = r_ovf ? r_u : (r_u + uquo);
                    if (r_ovf) begin
                        n_err = 1'b1;
                    end
                    if (r_op == OP_FRAC) begin
                        n_remreg = neg_if(r_neg, urem);
                    end else if (urem >= (r_d - urem)) begin
                        uf = uf + 1'b1;
                    end
                    n_res   = neg_if(r_neg, uf);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // signed divide launch
        if (fire) begin
            div_go = 1'b1;
            n_sq   = sa[WordW-1] ^ sb[WordW-1];
            n_sr   = sa[WordW-1];
        end
    end

    // divider operands: signed path uses magnitudes, fraction path is unsigned
    always_comb begin
        if (r_state == S_DIVA) begin
            div_num = v;
            div_den = r_d;
        end else if (r_state == S_MUL2) begin
            div_num = n_u;
            div_den = r_d;
        end else begin
            div_num = mag(sa);
            div_den = mag(sb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_err    <= 1'b0;
            r_remreg <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_err    <= n_err;
            r_remreg <= n_remreg;
            if (r_state == S_OUT && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op <= i_s_tuser;
            r_x  <= i_s_tdata[32:1];
            r_n  <= i_s_tdata[64:33];
            r_y  <= i_s_tdata[96:65];
            r_mx <= i_s_tdata[127:97];
            r_d  <= i_s_tdata[159:128];
        end else begin
            r_x <= n_x;
            r_n <= n_n;
        end
        r_res  <= n_res;
        r_t    <= n_t;
        r_u    <= n_u;
        r_q1   <= n_q1;
        r_neg  <= n_neg;
        r_xneg <= n_xneg;
        r_ovf  <= n_ovf;
        r_sq   <= n_sq;
        r_sr   <= n_sr;
        if (r_state == S_OUT && (!r_ovalid || i_m_tready)) begin
            r_odata <= {7'd0, r_err, r_remreg, r_res};
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule
`default_nettype wire

/* verif/scaled_muldiv_unit_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module scaled_muldiv_unit_tb;
    import smd_pkg::*;

    // one input transaction: request type plus packed operand fields
    typedef struct {
        t_op         op;
        logic        clr;
        logic [31:0] x;
        logic [31:0] n;
        logic [31:0] y;
        logic [30:0] mx;
        logic [31:0] d;
    } t_req;

    // one output transaction
    typedef struct {
        logic [31:0] res;
        logic [31:0] rem;
        logic        err;
    } t_ans;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [159:0] i_s_tdata;  // clear_error, operand_x, operand_n, operand_y, mag_limit,
                              // operand_d
    logic [1:0]   i_s_tuser;  // req_type
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [71:0]  o_m_tdata;  // result, remainder, err_flag, zero pad

    scaled_muldiv_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // predictor state mirrors the block's sticky flag and remainder register
    logic        mdl_err;
    logic [31:0] mdl_rem;

    t_req pending_reqs[$];
    t_ans expected_answers[$];
    int   fail_count;
    bit   hold_for_drain;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] abs32(input logic [31:0] a);
        return a[31] ? 32'd0 - a : a;
    endfunction

    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] q;
        if (b == 32'd0) return 32'd0;
        q = abs32(a) / abs32(b);
        return (a[31] ^ b[31]) ? 32'd0 - q : q;
    endfunction

    function automatic logic [31:0] mod_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        if (b == 32'd0) return 32'd0;
        r = abs32(a) % abs32(b);
        return a[31] ? 32'd0 - r : r;
    endfunction

    // 1.5-precision x*n/d on unsigned operands, 15-bit split; d nonzero
    function automatic logic [31:0] split_muldiv(input logic [31:0] xx, input logic [31:0] nn,
                                                 input logic [31:0] d, output logic [31:0] r);
        logic [31:0] t, u, v;
        t = {17'd0, xx[14:0]} * nn;
        u = (xx >> 15) * nn + (t >> 15);
        v = (u % d) * 32'h8000 + {17'd0, t[14:0]};
        if (u / d >= 32'h8000)
            mdl_err = 1'b1;
        else
            u = 32'h8000 * (u / d) + v / d;
        r = v % d;
        return u;
    endfunction

    function automatic t_ans scaled_arith(input t_req q);
        t_ans        a;
        logic [31:0] x, n, u, r;
        logic        flip;
        x = q.x;
        n = q.n;
        a.res = 32'd0;
        if (q.clr) mdl_err = 1'b0;
        case (q.op)
            OP_MULT_ADD: begin
                if (n == 32'd0) begin
                    a.res = q.y;
                end else begin
                    if (n[31]) begin
                        x = 32'd0 - x;
                        n = 32'd0 - n;
                    end
                    // signed compares against the wrapped bounds
                    if ($signed(x) <= $signed(div_trunc({1'b0, q.mx} - q.y, n)) &&
                        $signed(32'd0 - x) <= $signed(div_trunc({1'b0, q.mx} + q.y, n)))
                        a.res = n * x + q.y;
                    else
                        mdl_err = 1'b1;
                end
            end
            OP_DIV_N: begin
                if (n == 32'd0) begin
                    mdl_err = 1'b1;
                    mdl_rem = x;
                end else begin
                    flip = n[31];
                    if (flip) begin
                        x = 32'd0 - x;
                        n = 32'd0 - n;
                    end
                    if (!x[31]) begin
                        r = mod_trunc(x, n);
                        a.res = div_trunc(x, n);
                    end else begin
                        r = 32'd0 - mod_trunc(32'd0 - x, n);
                        a.res = 32'd0 - div_trunc(32'd0 - x, n);
                    end
                    mdl_rem = flip ? 32'd0 - r : r;
                end
            end
            default: begin
                if (q.d == 32'd0) begin
                    mdl_err = 1'b1;
                end else if (q.op == OP_FRAC) begin
                    u = split_muldiv(abs32(x), n, q.d, r);
                    mdl_rem = x[31] ? 32'd0 - r : r;
                    a.res = x[31] ? 32'd0 - u : u;
                end else begin
                    flip = x[31] ^ n[31];
                    u = split_muldiv(abs32(x), abs32(n), q.d, r);
                    if (r >= q.d - r) u = u + 32'd1;
                    a.res = flip ? 32'd0 - u : u;
                end
            end
        endcase
        a.rem = mdl_rem;
        a.err = mdl_err;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    // driver: one transaction at a time from the pending queue, random gaps
    int   send_gap;
    t_req cur_req;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tuser  <= 2'd0;
            send_gap   <= 0;
        end else if (i_s_tvalid && o_s_tready) begin
            expected_answers.push_back(scaled_arith(cur_req));
            i_s_tvalid <= 1'b0;
            send_gap   <= $urandom_range(0, 3);
        end else if (!i_s_tvalid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0 &&
                         !(hold_for_drain && expected_answers.size() > 0)) begin
                cur_req = pending_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= cur_req.op;
                i_s_tdata  <= {cur_req.d, cur_req.mx, cur_req.y, cur_req.n, cur_req.x,
                               cur_req.clr};
            end
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    int   recv_gap;
    t_ans want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            recv_gap   <= 0;
        end else if (o_m_tvalid && i_m_tready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[31:0], 32'd0);
            end else begin
                want = expected_answers.pop_front();
                if (o_m_tdata[31:0] !== want.res)
                    report_mismatch("result", o_m_tdata[31:0], want.res);
                if (o_m_tdata[63:32] !== want.rem)
                    report_mismatch("remainder", o_m_tdata[63:32], want.rem);
                if (o_m_tdata[64] !== want.err)
                    report_mismatch("err_flag", {31'd0, o_m_tdata[64]}, {31'd0, want.err});
            end
            recv_gap <= $urandom_range(0, 3);
            i_m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return 32'hffff_ffff;
            4: return $urandom_range(0, 70000);
            5: return 32'd0 - $urandom_range(0, 70000);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_req(input t_op op, input logic clr, input logic [31:0] x,
                             input logic [31:0] n, input logic [31:0] y,
                             input logic [30:0] mx, input logic [31:0] d);
        t_req q;
        q.op = op; q.clr = clr; q.x = x; q.n = n; q.y = y; q.mx = mx; q.d = d;
        pending_reqs.push_back(q);
    endtask

    initial begin
        t_req q;
        fail_count     = 0;
        hold_for_drain = 1'b0;
        mdl_err        = 1'b0;
        mdl_rem        = 32'd0;
        i_rst_n        = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: n zero, overflow, divide by zero, split overflow, rounding, clearing
        queue_req(OP_MULT_ADD, 1'b0, 32'd5, 32'd0, 32'hdead_beef, 31'd0, 32'd0);
        queue_req(OP_MULT_ADD, 1'b0, 32'd100, 32'd3, 32'd7, 31'h7fff_ffff, 32'd1);
        queue_req(OP_MULT_ADD, 1'b0, 32'h7fff_ffff, 32'd2, 32'd0, 31'h7fff_ffff, 32'd1);
        queue_req(OP_MULT_ADD, 1'b1, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000,
                  31'd1000, 32'd1);
        queue_req(OP_MULT_ADD, 1'b1, 32'hffff_fff0, 32'h8000_0000, 32'h7fff_ffff,
                  31'h7fff_ffff, 32'd1);
        queue_req(OP_DIV_N, 1'b1, 32'd17, 32'd5, 32'd0, 31'd0, 32'd0);
        queue_req(OP_DIV_N, 1'b0, 32'hffff_ffef, 32'd5, 32'd0, 31'd0, 32'd0);
        queue_req(OP_DIV_N, 1'b0, 32'd17, 32'hffff_fffb, 32'd0, 31'd0, 32'd0);
        queue_req(OP_DIV_N, 1'b0, 32'h8000_0000, 32'hffff_ffff, 32'd0, 31'd0, 32'd0);
        queue_req(OP_DIV_N, 1'b0, 32'h1234_5678, 32'd0, 32'd0, 31'd0, 32'd0);
        queue_req(OP_MULT_ADD, 1'b1, 32'd1, 32'd1, 32'd1, 31'd10, 32'd0);
        queue_req(OP_FRAC, 1'b0, 32'h0001_0000, 32'd3, 32'd0, 31'd0, 32'd7);
        queue_req(OP_FRAC, 1'b0, 32'h8000_0000, 32'hffff_ffff, 32'd0, 31'd0, 32'hffff_ffff);
        queue_req(OP_FRAC, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 31'd0, 32'd1);
        queue_req(OP_FRAC, 1'b1, 32'd9, 32'd9, 32'd0, 31'd0, 32'd0);
        queue_req(OP_FRAC_RND, 1'b1, 32'd7, 32'd1, 32'd0, 31'd0, 32'd2);
        queue_req(OP_FRAC_RND, 1'b0, 32'hffff_fff9, 32'd1, 32'd0, 31'd0, 32'd2);
        queue_req(OP_FRAC_RND, 1'b0, 32'd5, 32'h8000_0000, 32'd0, 31'd0, 32'd3);
        queue_req(OP_FRAC_RND, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'd0, 31'd0, 32'd1);
        queue_req(OP_FRAC_RND, 1'b0, 32'd1, 32'd1, 32'd0, 31'd0, 32'd0);
        queue_req(OP_FRAC_RND, 1'b1, 32'd10, 32'd10, 32'd0, 31'd0, 32'hffff_ffff);

        // random part
        for (int i = 0; i < 1000; i++) begin
            q.op  = t_op'($urandom_range(0, 3));
            q.clr = ($urandom_range(0, 3) == 0);
            q.x   = pick_word();
            q.n   = pick_word();
            q.y   = pick_word();
            q.mx  = ($urandom_range(0, 3) == 0) ? 31'h7fff_ffff : 31'($urandom);
            q.d   = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_word();
            pending_reqs.push_back(q);
            // halfway: let the sender stop until every result has drained
            if (i == 500) begin
                wait (pending_reqs.size() == 0);
                hold_for_drain = 1'b1;
                wait (expected_answers.size() == 0 && !i_s_tvalid);
                @(posedge i_clk);
                hold_for_drain = 1'b0;
            end
        end
        wait (pending_reqs.size() == 0 && !i_s_tvalid);
        wait (expected_answers.size() == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && expected_answers.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog: ~1020 items, each with block time, send gap and receive stall, several times over
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire

/* scaled_muldiv_unit.f */
sv/smd_pkg.sv
sv/smd_mul.sv
sv/smd_div.sv
sv/scaled_muldiv_unit.sv
verif/scaled_muldiv_unit_tb.sv
